/* hdl/hbbc_pkg.sv */
// shared types and constants for the hashed block buffer cache
package hbbc_pkg;

  localparam int BKT_W = 4;
  localparam int REF_W = 8;
  localparam int DEV_W = 8;
  localparam int BLK_W = 32;
  localparam int ENT_W = 5;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;

  localparam logic [REF_W-1:0] REF_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOBUF  = 2'd1,
    ST_COUNT  = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  // per-entry bookkeeping word
  typedef struct packed {
    logic [BKT_W-1:0] bkt;
    logic [REF_W-1:0] refs;
    logic             dv;
  } meta_t;

endpackage

/* hdl/hashed_block_buffer_cache.sv */
// hashed buffer cache tag manager with a single recency list in block memories
// get hashes the block number, scans the recency list, picks a victim starting at
// its bucket and, on a steal, moves it to the front of the recency list; release
// to zero adds a scan and a move; pin/unpin read and then update the bookkeeping.
// throughput: one request at a time, bounded by the one-entry-per-cycle scan of the
// recency memory. a finished result may wait in the output register.
// reset: synchronous; afterward an init sweep fills all memories
module hashed_block_buffer_cache #(
  parameter int ENTRIES = 32,
  parameter int BUCKETS = 13
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // op[1:0], device[9:2], block_number[41:10], entry[46:42], zero pad
  input  logic [hbbc_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // entry_out[4:0], hit[5], fill_needed[6], status[8:7], zero pad
  output logic [hbbc_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import hbbc_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int NB = 1 << BKT_W;
  localparam logic [CW-1:0] N_C = CW'(ENTRIES);
  localparam logic [BKT_W-1:0] BLAST = BKT_W'(BUCKETS - 1);
  localparam logic [4:0] BMOD = 5'(BUCKETS);
  localparam logic [8:0] ENT_LIM = 9'(ENTRIES);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_HASH  = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_PICK  = 9'b000010000,
    S_MREAD = 9'b000100000,
    S_MUPD  = 9'b001000000,
    S_MOVE  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // memories
  logic [IW-1:0]            rec_mem  [ENTRIES];
  meta_t                    meta_mem [ENTRIES];
  logic [DEV_W+BLK_W-1:0]   tag_mem  [ENTRIES];

  logic [IW-1:0]            rec_rdata_r;
  meta_t                    meta_rdata_r;
  logic [DEV_W+BLK_W-1:0]   tag_rdata_r;

  logic                     rec_we, meta_we, tag_we;
  logic [IW-1:0]            rec_raddr, rec_waddr, rec_wdata;
  logic [IW-1:0]            meta_raddr, meta_waddr, tag_waddr;
  meta_t                    meta_wdata;
  logic [DEV_W+BLK_W-1:0]   tag_wdata;

  // request registers
  op_t              op_r, op_nxt;
  logic [DEV_W-1:0] dev_r, dev_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic [ENT_W-1:0] ent_r, ent_nxt;
  logic [BLK_W-1:0] hsh_r, hsh_nxt;
  logic [2:0]       hcnt_r, hcnt_nxt;
  logic [BKT_W-1:0] id_r, id_nxt;

  // scan pipeline
  logic [CW-1:0]    p_r, p_nxt;
  logic             s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt;
  logic [IW-1:0]    s1_p_r, s1_p_nxt, s2_p_r, s2_p_nxt, s2_c_r, s2_c_nxt;
  logic             hit_v_r, hit_v_nxt;
  logic [IW-1:0]    hit_e_r, hit_e_nxt;
  meta_t            hit_m_r, hit_m_nxt;
  logic [IW-1:0]    pos_r, pos_nxt;
  logic [NB-1:0]    cand_v_r, cand_v_nxt;
  logic [IW-1:0]    cand_e_r [NB];
  logic [IW-1:0]    cand_p_r [NB];
  logic             cand_we;
  logic [BKT_W-1:0] cand_wa;

  // victim pick and list move
  logic [BKT_W-1:0] pk_b_r, pk_b_nxt, pk_k_r, pk_k_nxt;
  logic [IW-1:0]    q_r, q_nxt, wa_r, wa_nxt, mv_e_r, mv_e_nxt;
  logic             pend_r, pend_nxt;

  // init sweep
  logic [CW-1:0]    ini_r, ini_nxt;
  logic [BKT_W-1:0] ib_r, ib_nxt;

  // result
  logic [ENT_W-1:0] res_eo_r, res_eo_nxt;
  logic             res_hit_r, res_hit_nxt, res_fill_r, res_fill_nxt;
  status_t          res_st_r, res_st_nxt;
  logic             out_v_r, out_v_nxt;
  logic [OUT_TDATA_W-1:0] out_d_r, out_d_nxt;

  logic [BKT_W-1:0] hash_step;
  logic [IW-1:0]    ent_idx;
  logic             ent_bad;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign ent_idx    = IW'(ent_r);
  assign ent_bad    = ({4'b0000, ent_r} >= ENT_LIM);

  // four bits of the block number per cycle, remainder kept below BUCKETS
  always_comb begin
    logic [4:0] t;
    logic [BKT_W-1:0] r;
    r = id_r;
    for (int i = 0; i < 4; i++) begin
      t = {r, hsh_r[BLK_W-1-i]};
      if (t >= BMOD) begin
        t = t - BMOD;
      end
      r = t[BKT_W-1:0];
    end
    hash_step = r;
  end

  // memory ports
  always_ff @(posedge clk) begin
    rec_rdata_r  <= rec_mem[rec_raddr];
    meta_rdata_r <= meta_mem[meta_raddr];
    tag_rdata_r  <= tag_mem[meta_raddr];
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
  end

  // free-candidate table, one slot per bucket
  always_ff @(posedge clk) begin
    if (cand_we) begin
      cand_e_r[cand_wa] <= s2_c_r;
      cand_p_r[cand_wa] <= s2_p_r;
    end
  end

  // control and datapath next state
  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r; dev_nxt = dev_r; blk_nxt = blk_r; ent_nxt = ent_r;
    hsh_nxt = hsh_r; hcnt_nxt = hcnt_r; id_nxt = id_r;
    p_nxt = p_r; s1_v_nxt = 1'b0; s1_p_nxt = s1_p_r;
    s2_v_nxt = 1'b0; s2_p_nxt = s2_p_r; s2_c_nxt = s2_c_r;
    hit_v_nxt = hit_v_r; hit_e_nxt = hit_e_r; hit_m_nxt = hit_m_r;
    pos_nxt = pos_r; cand_v_nxt = cand_v_r;
    cand_we = 1'b0; cand_wa = '0;
    pk_b_nxt = pk_b_r; pk_k_nxt = pk_k_r;
    q_nxt = q_r; wa_nxt = wa_r; mv_e_nxt = mv_e_r; pend_nxt = pend_r;
    ini_nxt = ini_r; ib_nxt = ib_r;
    res_eo_nxt = res_eo_r; res_hit_nxt = res_hit_r;
    res_fill_nxt = res_fill_r; res_st_nxt = res_st_r;
    out_v_nxt = out_v_r; out_d_nxt = out_d_r;
    rec_we = 1'b0; rec_waddr = '0; rec_wdata = '0; rec_raddr = '0;
    meta_we = 1'b0; meta_waddr = '0; meta_wdata = '0; meta_raddr = '0;
    tag_we = 1'b0; tag_waddr = '0; tag_wdata = '0;

    // output register drains independently
    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        rec_we = 1'b1; rec_waddr = ini_r[IW-1:0];
        rec_wdata = IW'(N_C - 1'b1 - ini_r);
        meta_we = 1'b1; meta_waddr = ini_r[IW-1:0];
        meta_wdata = '{bkt: ib_r, refs: '0, dv: 1'b0};
        tag_we = 1'b1; tag_waddr = ini_r[IW-1:0]; tag_wdata = '0;
        ib_nxt = (ib_r == BLAST) ? '0 : ib_r + 1'b1;
        ini_nxt = ini_r + 1'b1;
        if (ini_r == N_C - 1'b1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt  = op_t'(in_tdata[1:0]);
          dev_nxt = in_tdata[9:2];
          blk_nxt = in_tdata[41:10];
          ent_nxt = in_tdata[46:42];
          hsh_nxt = in_tdata[41:10];
          hcnt_nxt = '0; id_nxt = '0;
          res_eo_nxt = in_tdata[46:42]; res_hit_nxt = 1'b0;
          res_fill_nxt = 1'b0; res_st_nxt = ST_OK;
          if (op_t'(in_tdata[1:0]) == OP_GET) begin
            state_nxt = S_HASH;
          end else if ({4'b0000, in_tdata[46:42]} >= ENT_LIM) begin
            res_st_nxt = ST_COUNT;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MREAD;
          end
        end
      end
      S_HASH: begin
        id_nxt = hash_step;
        hsh_nxt = hsh_r << 4;
        hcnt_nxt = hcnt_r + 1'b1;
        if (hcnt_r == 3'd7) begin
          p_nxt = '0; hit_v_nxt = 1'b0; cand_v_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // stage 0: read the recency list
        rec_raddr = p_r[IW-1:0];
        if (p_r != N_C) begin
          s1_v_nxt = 1'b1; s1_p_nxt = p_r[IW-1:0];
          p_nxt = p_r + 1'b1;
        end
        // stage 1: read tag and bookkeeping of the listed entry
        meta_raddr = rec_rdata_r;
        if (s1_v_r) begin
          s2_v_nxt = 1'b1; s2_p_nxt = s1_p_r; s2_c_nxt = rec_rdata_r;
        end
        // stage 2: compare
        if (s2_v_r) begin
          if (op_r == OP_GET) begin
            if (!hit_v_r && meta_rdata_r.bkt == id_r &&
                tag_rdata_r == {dev_r, blk_r}) begin
              hit_v_nxt = 1'b1; hit_e_nxt = s2_c_r; hit_m_nxt = meta_rdata_r;
            end
            if (meta_rdata_r.refs == '0) begin
              cand_we = 1'b1; cand_wa = meta_rdata_r.bkt;
              cand_v_nxt[meta_rdata_r.bkt] = 1'b1;
            end
          end else if (s2_c_r == ent_idx) begin
            pos_nxt = s2_p_r;
          end
        end
        if (p_r == N_C && !s1_v_r && !s2_v_r) begin
          if (op_r != OP_GET) begin
            q_nxt = pos_r; mv_e_nxt = ent_idx; pend_nxt = 1'b0;
            state_nxt = S_MOVE;
          end else if (hit_v_r) begin
            res_eo_nxt = ENT_W'(hit_e_r); res_hit_nxt = 1'b1;
            if (hit_m_r.refs == REF_MAX) begin
              res_st_nxt = ST_COUNT;
            end else begin
              meta_we = 1'b1; meta_waddr = hit_e_r;
              meta_wdata = '{bkt: hit_m_r.bkt, refs: hit_m_r.refs + 1'b1, dv: 1'b1};
              res_fill_nxt = !hit_m_r.dv;
            end
            state_nxt = S_DONE;
          end else begin
            pk_b_nxt = id_r; pk_k_nxt = '0;
            state_nxt = S_PICK;
          end
        end
      end
      S_PICK: begin
        if (cand_v_r[pk_b_r]) begin
          tag_we = 1'b1; tag_waddr = cand_e_r[pk_b_r]; tag_wdata = {dev_r, blk_r};
          meta_we = 1'b1; meta_waddr = cand_e_r[pk_b_r];
          meta_wdata = '{bkt: id_r, refs: REF_W'(1), dv: 1'b1};
          res_eo_nxt = ENT_W'(cand_e_r[pk_b_r]); res_fill_nxt = 1'b1;
          if (pk_k_r != '0) begin
            q_nxt = cand_p_r[pk_b_r]; mv_e_nxt = cand_e_r[pk_b_r]; pend_nxt = 1'b0;
            state_nxt = S_MOVE;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (pk_k_r == BLAST) begin
          res_eo_nxt = '0; res_st_nxt = ST_NOBUF;
          state_nxt = S_DONE;
        end else begin
          pk_k_nxt = pk_k_r + 1'b1;
          pk_b_nxt = (pk_b_r == BLAST) ? '0 : pk_b_r + 1'b1;
        end
      end
      S_MREAD: begin
        meta_raddr = ent_idx;
        state_nxt = S_MUPD;
      end
      S_MUPD: begin
        meta_waddr = ent_idx;
        state_nxt = S_DONE;
        if (op_r == OP_PIN) begin
          if (meta_rdata_r.refs == REF_MAX) begin
            res_st_nxt = ST_COUNT;
          end else begin
            meta_we = 1'b1;
            meta_wdata = '{bkt: meta_rdata_r.bkt, refs: meta_rdata_r.refs + 1'b1,
                           dv: meta_rdata_r.dv};
          end
        end else if (meta_rdata_r.refs == '0) begin
          res_st_nxt = ST_COUNT;
        end else begin
          meta_we = 1'b1;
          meta_wdata = '{bkt: meta_rdata_r.bkt, refs: meta_rdata_r.refs - 1'b1,
                         dv: meta_rdata_r.dv};
          if (op_r == OP_RELEASE && meta_rdata_r.refs == REF_W'(1)) begin
            p_nxt = '0; pos_nxt = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_MOVE: begin
        // shift list positions down by one toward the entry, then put it in front
        rec_raddr = q_r - 1'b1;
        if (pend_r) begin
          rec_we = 1'b1; rec_waddr = wa_r; rec_wdata = rec_rdata_r;
        end
        if (q_r != '0) begin
          wa_nxt = q_r; pend_nxt = 1'b1; q_nxt = q_r - 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          rec_we = 1'b1; rec_waddr = '0; rec_wdata = mv_e_r;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt = 1'b1;
          out_d_nxt = {7'b0, res_st_r, res_fill_r, res_hit_r, res_eo_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ini_r <= '0; ib_r <= '0;
      s1_v_r <= 1'b0; s2_v_r <= 1'b0;
      hit_v_r <= 1'b0; cand_v_r <= '0;
      pend_r <= 1'b0; out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ini_r <= ini_nxt; ib_r <= ib_nxt;
      s1_v_r <= s1_v_nxt; s2_v_r <= s2_v_nxt;
      hit_v_r <= hit_v_nxt; cand_v_r <= cand_v_nxt;
      pend_r <= pend_nxt; out_v_r <= out_v_nxt;
    end
    op_r <= op_nxt; dev_r <= dev_nxt; blk_r <= blk_nxt; ent_r <= ent_nxt;
    hsh_r <= hsh_nxt; hcnt_r <= hcnt_nxt; id_r <= id_nxt;
    p_r <= p_nxt; s1_p_r <= s1_p_nxt; s2_p_r <= s2_p_nxt; s2_c_r <= s2_c_nxt;
    hit_e_r <= hit_e_nxt; hit_m_r <= hit_m_nxt; pos_r <= pos_nxt;
    pk_b_r <= pk_b_nxt; pk_k_r <= pk_k_nxt;
    q_r <= q_nxt; wa_r <= wa_nxt; mv_e_r <= mv_e_nxt;
    res_eo_r <= res_eo_nxt; res_hit_r <= res_hit_nxt;
    res_fill_r <= res_fill_nxt; res_st_r <= res_st_nxt;
    out_d_r <= out_d_nxt;
  end

  // bucket hash never reaches the bucket count
  a_hash_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (id_r <= BLAST))
    else $error("bucket index out of range");

  // a hit result never reports a missing buffer
  a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_hit_r) |-> (res_st_r != ST_NOBUF))
    else $error("hit with no-free status");

  // the scan pipeline only carries data while scanning
  a_scan_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> $past(state_r == S_SCAN))
    else $error("scan stage valid outside scan");

  // an out-of-range entry never reaches the bookkeeping update
  a_ent_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUPD) |-> !ent_bad)
    else $error("bad entry index updated");

endmodule
